>>> hw/rtl/sri_pkg.sv
`default_nettype none
package sri_pkg;

    // Width of the result channel's data bus: the hit bit padded to a byte.
    localparam int OUT_TDATA_BITS = 8;

    // Sign comparisons of the segment endpoints against the rectangle corner
    // coordinates, indexed [endpoint][corner]: endpoint 0 is (seg_x0, seg_y0),
    // endpoint 1 is (seg_x1, seg_y1); corner 0 is rect_xa/ya, corner 1 rect_xb/yb.
    typedef struct packed {
        logic [1:0][1:0] x_lt;
        logic [1:0][1:0] x_gt;
        logic [1:0][1:0] y_lt;
        logic [1:0][1:0] y_gt;
    } cmp_t;

    // Decisions that do not need the cross products.
    // Edge e runs from rectangle corner e to corner e+1 (mod 4), with corners
    // (xa,ya), (xb,ya), (xb,yb), (xa,yb).
    typedef struct packed {
        logic       enclosed;
        logic [3:0] box_miss;
    } hitf_t;

endpackage
`default_nettype wire

>>> hw/rtl/sri_prep.sv
`default_nettype none
module sri_prep
    import sri_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    input  wire logic [8*COORD_BITS-1:0]      in_data,
    output logic                              up_ready,
    input  wire logic                         down_ready,
    output logic                              out_valid,
    output logic signed [COORD_BITS:0]        dx,
    output logic signed [COORD_BITS:0]        dy,
    output logic signed [COORD_BITS:0]        ex_a,
    output logic signed [COORD_BITS:0]        ex_b,
    output logic signed [COORD_BITS:0]        ey_a,
    output logic signed [COORD_BITS:0]        ey_b,
    output cmp_t                              cmp
);

    localparam int DW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] sx, sy, tx, ty, xa, ya, xb, yb;
    logic signed [1:0][COORD_BITS-1:0] px, py, rx, ry;

    logic                  valid_reg;
    logic signed [DW-1:0]  dx_reg, dy_reg, ex_a_reg, ex_b_reg, ey_a_reg, ey_b_reg;
    logic signed [DW-1:0]  dx_next, dy_next, ex_a_next, ex_b_next, ey_a_next, ey_b_next;
    cmp_t                  cmp_reg, cmp_next;

    assign sx = in_data[0*COORD_BITS +: COORD_BITS];
    assign sy = in_data[1*COORD_BITS +: COORD_BITS];
    assign tx = in_data[2*COORD_BITS +: COORD_BITS];
    assign ty = in_data[3*COORD_BITS +: COORD_BITS];
    assign xa = in_data[4*COORD_BITS +: COORD_BITS];
    assign ya = in_data[5*COORD_BITS +: COORD_BITS];
    assign xb = in_data[6*COORD_BITS +: COORD_BITS];
    assign yb = in_data[7*COORD_BITS +: COORD_BITS];

    assign px = {tx, sx};
    assign py = {ty, sy};
    assign rx = {xb, xa};
    assign ry = {yb, ya};

    always_comb begin
        dx_next   = DW'(tx) - DW'(sx);
        dy_next   = DW'(ty) - DW'(sy);
        ex_a_next = DW'(sx) - DW'(xa);
        ex_b_next = DW'(sx) - DW'(xb);
        ey_a_next = DW'(sy) - DW'(ya);
        ey_b_next = DW'(sy) - DW'(yb);
        for (int p = 0; p < 2; p++) begin
            for (int r = 0; r < 2; r++) begin
                cmp_next.x_lt[p][r] = $signed(px[p]) < $signed(rx[r]);
                cmp_next.x_gt[p][r] = $signed(px[p]) > $signed(rx[r]);
                cmp_next.y_lt[p][r] = $signed(py[p]) < $signed(ry[r]);
                cmp_next.y_gt[p][r] = $signed(py[p]) > $signed(ry[r]);
            end
        end
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && in_valid) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            ex_a_reg <= ex_a_next;
            ex_b_reg <= ex_b_next;
            ey_a_reg <= ey_a_next;
            ey_b_reg <= ey_b_next;
            cmp_reg  <= cmp_next;
        end
    end

    assign out_valid = valid_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;
    assign ex_a      = ex_a_reg;
    assign ex_b      = ex_b_reg;
    assign ey_a      = ey_a_reg;
    assign ey_b      = ey_b_reg;
    assign cmp       = cmp_reg;

endmodule
`default_nettype wire

>>> hw/rtl/sri_mult.sv
`default_nettype none
module sri_mult
    import sri_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    input  wire logic signed [COORD_BITS:0]     dx,
    input  wire logic signed [COORD_BITS:0]     dy,
    input  wire logic signed [COORD_BITS:0]     ex_a,
    input  wire logic signed [COORD_BITS:0]     ex_b,
    input  wire logic signed [COORD_BITS:0]     ey_a,
    input  wire logic signed [COORD_BITS:0]     ey_b,
    input  wire cmp_t                           cmp,
    output logic                                up_ready,
    input  wire logic                           down_ready,
    output logic                                out_valid,
    output logic signed [2*COORD_BITS+1:0]      pxa,
    output logic signed [2*COORD_BITS+1:0]      pxb,
    output logic signed [2*COORD_BITS+1:0]      pya,
    output logic signed [2*COORD_BITS+1:0]      pyb,
    output hitf_t                               flags
);

    localparam int PW = 2 * COORD_BITS + 2;

    logic                 valid_reg;
    logic signed [PW-1:0] pxa_reg, pxb_reg, pya_reg, pyb_reg;
    logic signed [PW-1:0] pxa_next, pxb_next, pya_next, pyb_next;
    hitf_t                flags_reg, flags_next;
    logic                 x_in, y_in, x_span_miss, y_span_miss;
    logic [1:0]           x_line_miss, y_line_miss;

    // Each cross product is (corner to first endpoint) x (segment direction).
    assign pxa_next = PW'(ex_a) * PW'(dy);
    assign pxb_next = PW'(ex_b) * PW'(dy);
    assign pya_next = PW'(ey_a) * PW'(dx);
    assign pyb_next = PW'(ey_b) * PW'(dx);

    always_comb begin
        // Both endpoints lie within the rectangle's span on each axis.
        x_in = 1'b1;
        y_in = 1'b1;
        for (int p = 0; p < 2; p++) begin
            x_in = x_in && (!cmp.x_lt[p][0] || !cmp.x_lt[p][1])
                        && (!cmp.x_gt[p][0] || !cmp.x_gt[p][1]);
            y_in = y_in && (!cmp.y_lt[p][0] || !cmp.y_lt[p][1])
                        && (!cmp.y_gt[p][0] || !cmp.y_gt[p][1]);
        end
        x_span_miss = (&cmp.x_gt) || (&cmp.x_lt);
        y_span_miss = (&cmp.y_gt) || (&cmp.y_lt);
        // Both endpoints strictly on one side of a single corner coordinate.
        for (int r = 0; r < 2; r++) begin
            x_line_miss[r] = (cmp.x_gt[0][r] && cmp.x_gt[1][r])
                          || (cmp.x_lt[0][r] && cmp.x_lt[1][r]);
            y_line_miss[r] = (cmp.y_gt[0][r] && cmp.y_gt[1][r])
                          || (cmp.y_lt[0][r] && cmp.y_lt[1][r]);
        end
        // For an axis-aligned edge, the turn test of the segment endpoints
        // against the edge fails only when the bounding boxes already miss,
        // so the box test covers it.
        flags_next.enclosed    = x_in && y_in;
        flags_next.box_miss[0] = x_span_miss || y_line_miss[0];
        flags_next.box_miss[1] = y_span_miss || x_line_miss[1];
        flags_next.box_miss[2] = x_span_miss || y_line_miss[1];
        flags_next.box_miss[3] = y_span_miss || x_line_miss[0];
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && in_valid) begin
            pxa_reg   <= pxa_next;
            pxb_reg   <= pxb_next;
            pya_reg   <= pya_next;
            pyb_reg   <= pyb_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign pxa       = pxa_reg;
    assign pxb       = pxb_reg;
    assign pya       = pya_reg;
    assign pyb       = pyb_reg;
    assign flags     = flags_reg;

endmodule
`default_nettype wire

>>> hw/rtl/sri_decide.sv
`default_nettype none
module sri_decide
    import sri_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    input  wire logic signed [2*COORD_BITS+1:0] pxa,
    input  wire logic signed [2*COORD_BITS+1:0] pxb,
    input  wire logic signed [2*COORD_BITS+1:0] pya,
    input  wire logic signed [2*COORD_BITS+1:0] pyb,
    input  wire hitf_t                          flags,
    output logic                                up_ready,
    input  wire logic                           down_ready,
    output logic                                out_valid,
    output logic                                hit
);

    localparam int PW = 2 * COORD_BITS + 2;
    localparam int VW = PW + 1;

    logic signed [3:0][PW-1:0] p_x, p_y;
    logic [3:0]                c_pos, c_neg;
    logic [3:0]                meets;
    logic signed [VW-1:0]      v;
    logic                      valid_reg;
    logic                      hit_reg, hit_next;

    // Corners in edge order: (xa,ya), (xb,ya), (xb,yb), (xa,yb).
    assign p_x = {pxa, pxb, pxb, pxa};
    assign p_y = {pyb, pyb, pya, pya};

    always_comb begin
        v = '0;
        for (int k = 0; k < 4; k++) begin
            v        = VW'($signed(p_x[k])) - VW'($signed(p_y[k]));
            c_neg[k] = v[VW-1];
            c_pos[k] = !v[VW-1] && (p_x[k] != p_y[k]);
        end
        // An edge is met unless its boxes miss or both of its corners lie
        // strictly on the same side of the segment's line.
        for (int e = 0; e < 4; e++) begin
            meets[e] = !flags.box_miss[e]
                    && !(c_pos[e] && c_pos[(e + 1) % 4])
                    && !(c_neg[e] && c_neg[(e + 1) % 4]);
        end
        hit_next = flags.enclosed || (|meets);
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && in_valid) begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign hit       = hit_reg;

endmodule
`default_nettype wire

>>> hw/rtl/segment_rectangle_intersect.sv
// Segment versus filled rectangle hit test.
// Input channel (s_): one item per segment/rectangle pair, eight signed
// coordinates of COORD_BITS each, packed in s_tdata. The rectangle corners may
// come in either order. Result channel (m_): one item per input item, carrying
// the hit bit in m_tdata[0]; it is set when the segment lies inside the
// rectangle or touches any of its edges, endpoints and collinear overlap
// included.
// The datapath has three register stages: coordinate differences and compares,
// four signed cross-product multipliers, and the sign tests that form the hit.
// m_tvalid rises once an accepted item has passed all three register stages;
// one item is accepted per cycle for as long as the receiver keeps up.
// Each stage holds its item when the stage after it is full and stalled, and
// an empty stage keeps taking items, so bubbles are squeezed out and the block
// still accepts up to two more items while a result waits on m_tready.
// s_tready follows m_tready combinationally through the stage valid bits.
// Reset (aresetn low at a clock edge) empties all stages; m_tvalid is low after.
`default_nettype none
module segment_rectangle_intersect
    import sri_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // seg_x0, seg_y0, seg_x1, seg_y1, rect_xa, rect_ya, rect_xb, rect_yb
    input  wire logic [8*COORD_BITS-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // hit, then zero padding
    output logic [OUT_TDATA_BITS-1:0]        m_tdata
);

    logic                          v1, v2, v3;
    logic                          rdy2, rdy3;
    logic signed [COORD_BITS:0]    dx, dy, ex_a, ex_b, ey_a, ey_b;
    cmp_t                          cmp;
    logic signed [2*COORD_BITS+1:0] pxa, pxb, pya, pyb;
    hitf_t                         flags;
    logic                          hit;

    sri_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .up_ready   (s_tready),
        .down_ready (rdy2),
        .out_valid  (v1),
        .dx         (dx),
        .dy         (dy),
        .ex_a       (ex_a),
        .ex_b       (ex_b),
        .ey_a       (ey_a),
        .ey_b       (ey_b),
        .cmp        (cmp)
    );

    sri_mult #(.COORD_BITS(COORD_BITS)) u_mult (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v1),
        .dx         (dx),
        .dy         (dy),
        .ex_a       (ex_a),
        .ex_b       (ex_b),
        .ey_a       (ey_a),
        .ey_b       (ey_b),
        .cmp        (cmp),
        .up_ready   (rdy2),
        .down_ready (rdy3),
        .out_valid  (v2),
        .pxa        (pxa),
        .pxb        (pxb),
        .pya        (pya),
        .pyb        (pyb),
        .flags      (flags)
    );

    sri_decide #(.COORD_BITS(COORD_BITS)) u_decide (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v2),
        .pxa        (pxa),
        .pxb        (pxb),
        .pya        (pya),
        .pyb        (pyb),
        .flags      (flags),
        .up_ready   (rdy3),
        .down_ready (m_tready),
        .out_valid  (v3),
        .hit        (hit)
    );

    assign m_tvalid = v3;
    assign m_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, hit};

endmodule
`default_nettype wire

>>> hw/rtl/sri_checker.sv
`default_nettype none
module sri_checker (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_tvalid,
    input wire logic                    s_tready,
    input wire logic                    m_tvalid,
    input wire logic                    m_tready,
    input wire logic [7:0]              m_tdata
);

    // A stalled result holds its item.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A ready receiver never blocks the input side.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while receiver ready");

    // With the receiver ready throughout, an item that enters comes out.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind segment_rectangle_intersect sri_checker u_sri_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
